// ===== rtl/first_fit_heap_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Implication checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// ---------------------------------------------------------------------------
// ffha_pkg
// Types, constants and helper functions of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

  localparam int MaxBlocks = 64;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = IdxW + 1;
  localparam int HdrBytes  = 16;
  localparam int OffW      = 24;
  localparam int AlignW    = 21;
  localparam int PowW      = AlignW + 1;
  localparam int PfW       = PowW + 1;
  localparam int NeedW     = OffW + 2;
  localparam int AddrW     = 32;
  localparam int OpW       = 2;
  localparam int StW       = 2;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;

  localparam logic [OpW-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OpW-1:0] OP_ALIGNED = 2'd1;
  localparam logic [OpW-1:0] OP_FREE    = 2'd2;

  localparam logic [StW-1:0] ST_OK      = 2'd0;
  localparam logic [StW-1:0] ST_NOFIT   = 2'd1;
  localparam logic [StW-1:0] ST_BADFREE = 2'd2;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic [OffW-1:0] start;
    logic [OffW-1:0] size;
    logic            used;
  } ent_t;

  localparam int EntW = $bits(ent_t);

  // Smallest power of two that is not below the requested alignment.
  function automatic logic [PowW-1:0] pow2_ceil(input logic [AlignW-1:0] align);
    logic [PowW-1:0] a;
    a = PowW'(1);
    for (int k = 0; k < AlignW; k++) begin
      if ((PowW'(1) << k) < PowW'(align)) begin
        a = PowW'(1) << (k + 1);
      end
    end
    return a;
  endfunction

  // Bytes plus one header, rounded up to a header multiple.
  function automatic logic [NeedW-1:0] round_hdr(input logic [NeedW-1:0] bytes);
    return (bytes + NeedW'(2 * HdrBytes - 1)) & ~NeedW'(HdrBytes - 1);
  endfunction

  function automatic logic [AddrW-1:0] payload_of(input logic [AddrW-1:0] base,
                                                  input ent_t e);
    return base + AddrW'(e.start) + AddrW'(HdrBytes);
  endfunction

endpackage

// ===== rtl/ffha_if.sv =====
// ---------------------------------------------------------------------------
// ffha request and response channels
// Valid/ready channels carrying one allocator request or one result.
// ---------------------------------------------------------------------------
interface ffha_req_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [OffW-1:0]   request_size;
  logic [AlignW-1:0] align_bytes;
  logic [AddrW-1:0]  free_address;

  modport source (output valid, opcode, request_size, align_bytes, free_address,
                  input ready);
  modport sink (input valid, opcode, request_size, align_bytes, free_address,
                output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;

  logic             valid;
  logic             ready;
  logic [StW-1:0]   status;
  logic [AddrW-1:0] payload_address;

  modport source (output valid, status, payload_address, input ready);
  modport sink (input valid, status, payload_address, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// ---------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing over an address-ordered table.
// ---------------------------------------------------------------------------
// Usage: requests (allocate, aligned allocate, free) arrive on the req
// channel and each one produces exactly one transfer on the rsp channel with
// a status and a payload address. The heap base and heap size registers must
// be written by the user over the APB port only while the block is idle; the
// block itself does not enforce this. Writing the heap size leaves a single
// free block covering the whole heap. After reset there is no heap, so
// allocations fail and frees of a non-null address are rejected until it is
// written. The block table lives in a 64-entry RAM with registered read
// data. One request is handled at a time: a first-fit scan reads and then
// checks each entry visited, and a split or merge moves the entries behind
// it, reading and writing each in turn. The shortest requests are an ignored
// free or an unknown opcode; the longest is an aligned allocation at the
// front of a nearly full table that shifts the table three times.
// The result sits in an output register; the next request is accepted while
// it waits, but the following result is held until the receiver takes it.
// Reset clears the state machine, the block count and the output valid.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffha_req_if.sink                      req,
  ffha_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffha_pkg::PaddrW-1:0]   paddr,
  input  logic [ffha_pkg::PdataW-1:0]   pwdata,
  output logic [ffha_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import ffha_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_PREP     = 21'h000002,
    S_SCAN_RD  = 21'h000004,
    S_SCAN_CHK = 21'h000008,
    S_TAKE     = 21'h000010,
    S_INS_NXT  = 21'h000020,
    S_TAKEN    = 21'h000040,
    S_AL0      = 21'h000080,
    S_AL1      = 21'h000100,
    S_AL3      = 21'h000200,
    S_TAIL     = 21'h000400,
    S_TL1      = 21'h000800,
    S_TL2      = 21'h001000,
    S_RL0      = 21'h002000,
    S_RL1      = 21'h004000,
    S_RL2      = 21'h008000,
    S_SH_RD    = 21'h010000,
    S_SH_WR    = 21'h020000,
    S_FIN      = 21'h040000,
    S_SPARE0   = 21'h080000,
    S_SPARE1   = 21'h100000
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [CntW-1:0]   cnt_q, cnt_d, i_q, i_d, sp_q, sp_d, mv_q, mv_d;
  logic              up_q, up_d;
  logic [1:0]        dist_q, dist_d;
  ent_t              cur_q, cur_d, nxt_q, nxt_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [OffW-1:0]   reqsz_q, reqsz_d;
  logic [PowW-1:0]   a_q, a_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [NeedW-1:0]  need_q, need_d, keep_q, keep_d;
  logic [PfW-1:0]    al_q, al_d, pf_q, pf_d;
  logic [StW-1:0]    st_q, st_d;
  logic [AddrW-1:0]  pay_q, pay_d;
  logic [AddrW-1:0]  base_q;
  logic [OffW-1:0]   hsize_q;
  logic              ov_q;
  logic [StW-1:0]    ost_q;
  logic [AddrW-1:0]  opay_q;

  logic              ram_we;
  logic [CntW-1:0]   ram_waddr, ram_raddr;
  ent_t              ram_wdata, rdata;
  logic [EntW-1:0]   rdata_raw;

  logic              cfg_we;
  logic [PfW-1:0]    raw_c;
  logic [NeedW-1:0]  x_c;
  logic              split_c, nf_c, pvf_c;
  logic              out_load;

  ffha_ram #(
    .Width (EntW),
    .Depth (MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr[IdxW-1:0]),
    .rdata_o (rdata_raw)
  );

  assign rdata = ent_t'(rdata_raw);

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_SIZE) ? PdataW'(hsize_q) : base_q;

  assign req.ready = (state_q == S_IDLE);
  assign out_load  = (state_q == S_FIN) && (!ov_q || rsp.ready);
  assign rsp.valid = ov_q;
  assign rsp.status = ost_q;
  assign rsp.payload_address = opay_q;

  // Low bits of the raw payload address; the prefix never reaches bit PfW-1.
  assign raw_c = PfW'(base_q) + PfW'(cur_q.start) + PfW'(HdrBytes);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    sp_d      = sp_q;
    mv_d      = mv_q;
    up_d      = up_q;
    dist_d    = dist_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    op_d      = op_q;
    reqsz_d   = reqsz_q;
    a_d       = a_q;
    addr_d    = addr_q;
    need_d    = need_q;
    keep_d    = keep_q;
    al_d      = al_q;
    pf_d      = pf_q;
    st_d      = st_q;
    pay_d     = pay_q;
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = cur_q;
    ram_raddr = i_q;
    x_c       = '0;
    split_c   = 1'b0;
    nf_c      = 1'b0;
    pvf_c     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d    = req.opcode;
          reqsz_d = req.request_size;
          a_d     = pow2_ceil(req.align_bytes);
          addr_d  = req.free_address;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        x_c = (op_q == OP_ALIGNED)
            ? NeedW'(reqsz_q) + NeedW'(a_q) + NeedW'(HdrBytes)
            : NeedW'(reqsz_q);
        need_d = round_hdr(x_c);
        keep_d = round_hdr(NeedW'(reqsz_q));
        i_d    = '0;
        st_d   = ST_OK;
        pay_d  = '0;
        if (op_q == OP_ALLOC || op_q == OP_ALIGNED) begin
          state_d = S_SCAN_RD;
        end else if (op_q == OP_FREE && addr_q != '0) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN_RD: begin
        if (i_q >= cnt_q) begin
          st_d    = (op_q == OP_FREE) ? ST_BADFREE : ST_NOFIT;
          state_d = S_FIN;
        end else begin
          ram_raddr = i_q;
          state_d   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (op_q == OP_FREE) begin
          if (payload_of(base_q, rdata) == addr_q) begin
            cur_d = rdata;
            if (rdata.used) begin
              state_d = S_RL0;
            end else begin
              st_d    = ST_BADFREE;
              state_d = S_FIN;
            end
          end else begin
            i_d     = i_q + CntW'(1);
            state_d = S_SCAN_RD;
          end
        end else if (!rdata.used && NeedW'(rdata.size) >= need_q) begin
          cur_d   = rdata;
          state_d = S_TAKE;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_TAKE: begin
        split_c    = (NeedW'(cur_q.size) > need_q + NeedW'(HdrBytes)) &&
                     (cnt_q < CntW'(MaxBlocks));
        cur_d.used = 1'b1;
        if (split_c) begin
          cur_d.size  = need_q[OffW-1:0];
          nxt_d.start = cur_q.start + need_q[OffW-1:0];
          nxt_d.size  = cur_q.size - need_q[OffW-1:0];
          nxt_d.used  = 1'b0;
          up_d        = 1'b1;
          dist_d      = 2'd1;
          sp_d        = cnt_q - CntW'(1);
          mv_d        = cnt_q - CntW'(1) - i_q;
          ret_d       = S_INS_NXT;
          state_d     = S_SH_RD;
        end else begin
          state_d = S_TAKEN;
        end
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = cur_d;
      end
      S_INS_NXT: begin
        ram_we    = 1'b1;
        ram_waddr = i_q + CntW'(1);
        ram_wdata = nxt_q;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_TAKEN;
      end
      S_TAKEN: begin
        if (op_q == OP_ALLOC) begin
          pay_d   = payload_of(base_q, cur_q);
          state_d = S_FIN;
        end else if (cnt_q >= CntW'(MaxBlocks)) begin
          // No slot for the free prefix: give the block back and fail.
          st_d    = ST_NOFIT;
          state_d = S_RL0;
        end else begin
          al_d    = (raw_c + PfW'(a_q) + PfW'(HdrBytes - 1)) & ~(PfW'(a_q) - PfW'(1));
          state_d = S_AL0;
        end
      end
      S_AL0: begin
        pf_d      = al_q - raw_c;
        ram_raddr = i_q - CntW'(1);
        state_d   = S_AL1;
      end
      S_AL1: begin
        pvf_c       = (i_q != '0) && !rdata.used;
        cur_d.start = cur_q.start + OffW'(pf_q);
        cur_d.size  = cur_q.size - OffW'(pf_q);
        cur_d.used  = 1'b1;
        ram_we      = 1'b1;
        if (pvf_c) begin
          // The prefix joins the free predecessor; the table does not grow.
          ram_waddr      = i_q - CntW'(1);
          ram_wdata      = rdata;
          ram_wdata.size = rdata.size + OffW'(pf_q);
          state_d        = S_TAIL;
        end else begin
          ram_waddr       = i_q;
          ram_wdata.start = cur_q.start;
          ram_wdata.size  = OffW'(pf_q);
          ram_wdata.used  = 1'b0;
          up_d            = 1'b1;
          dist_d          = 2'd1;
          sp_d            = cnt_q - CntW'(1);
          mv_d            = cnt_q - CntW'(1) - i_q;
          ret_d           = S_AL3;
          state_d         = S_SH_RD;
        end
      end
      S_AL3: begin
        cnt_d   = cnt_q + CntW'(1);
        i_d     = i_q + CntW'(1);
        state_d = S_TAIL;
      end
      S_TAIL: begin
        split_c = (NeedW'(cur_q.size) > keep_q + NeedW'(HdrBytes)) &&
                  (cnt_q < CntW'(MaxBlocks));
        pay_d   = payload_of(base_q, cur_q);
        ram_we  = 1'b1;
        ram_waddr = i_q;
        if (split_c) begin
          cur_d.size  = keep_q[OffW-1:0];
          nxt_d.start = cur_q.start + keep_q[OffW-1:0];
          nxt_d.size  = cur_q.size - keep_q[OffW-1:0];
          nxt_d.used  = 1'b0;
          ram_raddr   = i_q + CntW'(1);
          if (i_q + CntW'(1) < cnt_q) begin
            state_d = S_TL1;
          end else begin
            state_d = S_TL2;
          end
        end else begin
          state_d = S_FIN;
        end
        ram_wdata = cur_d;
      end
      S_TL1: begin
        if (!rdata.used) begin
          // The trimmed tail merges into the free successor in place.
          ram_we         = 1'b1;
          ram_waddr      = i_q + CntW'(1);
          ram_wdata      = nxt_q;
          ram_wdata.size = nxt_q.size + rdata.size;
          state_d        = S_FIN;
        end else begin
          up_d    = 1'b1;
          dist_d  = 2'd1;
          sp_d    = cnt_q - CntW'(1);
          mv_d    = cnt_q - CntW'(1) - i_q;
          ret_d   = S_TL2;
          state_d = S_SH_RD;
        end
      end
      S_TL2: begin
        ram_we    = 1'b1;
        ram_waddr = i_q + CntW'(1);
        ram_wdata = nxt_q;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_FIN;
      end
      S_RL0: begin
        ram_raddr = i_q + CntW'(1);
        state_d   = S_RL1;
      end
      S_RL1: begin
        nxt_d     = rdata;
        ram_raddr = i_q - CntW'(1);
        state_d   = S_RL2;
      end
      S_RL2: begin
        nf_c    = (i_q + CntW'(1) < cnt_q) && !nxt_q.used;
        pvf_c   = (i_q != '0) && !rdata.used;
        ram_we  = 1'b1;
        up_d    = 1'b0;
        ret_d   = S_FIN;
        state_d = S_SH_RD;
        if (nf_c && pvf_c) begin
          ram_waddr      = i_q - CntW'(1);
          ram_wdata      = rdata;
          ram_wdata.size = rdata.size + cur_q.size + nxt_q.size;
          sp_d           = i_q + CntW'(2);
          dist_d         = 2'd2;
          mv_d           = cnt_q - i_q - CntW'(2);
          cnt_d          = cnt_q - CntW'(2);
        end else if (nf_c) begin
          ram_waddr      = i_q;
          ram_wdata      = cur_q;
          ram_wdata.size = cur_q.size + nxt_q.size;
          ram_wdata.used = 1'b0;
          sp_d           = i_q + CntW'(2);
          dist_d         = 2'd1;
          mv_d           = cnt_q - i_q - CntW'(2);
          cnt_d          = cnt_q - CntW'(1);
        end else if (pvf_c) begin
          ram_waddr      = i_q - CntW'(1);
          ram_wdata      = rdata;
          ram_wdata.size = rdata.size + cur_q.size;
          sp_d           = i_q + CntW'(1);
          dist_d         = 2'd1;
          mv_d           = cnt_q - i_q - CntW'(1);
          cnt_d          = cnt_q - CntW'(1);
        end else begin
          ram_waddr      = i_q;
          ram_wdata      = cur_q;
          ram_wdata.used = 1'b0;
          state_d        = S_FIN;
        end
      end
      S_SH_RD: begin
        if (mv_q == '0) begin
          state_d = ret_q;
        end else begin
          ram_raddr = sp_q;
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
        if (up_q) begin
          ram_waddr = sp_q + CntW'(1);
          sp_d      = sp_q - CntW'(1);
        end else begin
          ram_waddr = sp_q - CntW'(dist_q);
          sp_d      = sp_q + CntW'(1);
        end
        mv_d    = mv_q - CntW'(1);
        state_d = S_SH_RD;
      end
      S_FIN: begin
        if (!ov_q || rsp.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A heap size write rebuilds the table as one free block.
    if (cfg_we && paddr[2] == REG_HEAP_SIZE) begin
      ram_we          = 1'b1;
      ram_waddr       = '0;
      ram_wdata.start = '0;
      ram_wdata.size  = pwdata[OffW-1:0];
      ram_wdata.used  = 1'b0;
      cnt_d           = CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      base_q  <= '0;
      hsize_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp.ready) begin
        ov_q <= 1'b0;
      end
      if (cfg_we && paddr[2] == REG_HEAP_BASE) begin
        base_q <= pwdata;
      end
      if (cfg_we && paddr[2] == REG_HEAP_SIZE) begin
        hsize_q <= pwdata[OffW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    sp_q    <= sp_d;
    mv_q    <= mv_d;
    up_q    <= up_d;
    dist_q  <= dist_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    op_q    <= op_d;
    reqsz_q <= reqsz_d;
    a_q     <= a_d;
    addr_q  <= addr_d;
    need_q  <= need_d;
    keep_q  <= keep_d;
    al_q    <= al_d;
    pf_q    <= pf_d;
    st_q    <= st_d;
    pay_q   <= pay_d;
    if (out_load) begin
      ost_q  <= st_q;
      opay_q <= (st_q == ST_OK) ? pay_q : '0;
    end
  end

  `include "first_fit_heap_allocator_assert.svh"

  `FFHA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CntW'(MaxBlocks), "block count above table depth")
  `FFHA_ASSERT_SAME(a_shift_moves, state_q == S_SH_WR, mv_q != '0, "shift step with no entry left")
  `FFHA_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q == S_PREP, "accepted request not started")

endmodule

// ===== tb/ffha_checker.sv =====
// ---------------------------------------------------------------------------
// ffha_checker
// Watches the request, result and APB ports of the heap allocator. It keeps
// its own copy of the block table and predicts the result of every accepted
// request. Each result transfer is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module ffha_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffha_req_if                         req,
  ffha_rsp_if                         rsp,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [ffha_pkg::PaddrW-1:0] paddr_i,
  input  logic [ffha_pkg::PdataW-1:0] pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import ffha_pkg::*;

  typedef struct {
    logic [StW-1:0]   status;
    logic [AddrW-1:0] addr;
  } alloc_result_t;

  alloc_result_t   awaited_results[$];
  longint unsigned heap_base_q;
  longint unsigned blk_start[MaxBlocks];
  longint unsigned blk_size[MaxBlocks];
  bit              blk_used[MaxBlocks];
  int              blk_cnt;

  assign pending_o = awaited_results.size();

  function automatic void insert_blk(int i, longint unsigned s, longint unsigned sz, bit u);
    if (blk_cnt >= MaxBlocks || i > blk_cnt) return;
    for (int j = blk_cnt; j > i; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_size[j]  = blk_size[j-1];
      blk_used[j]  = blk_used[j-1];
    end
    blk_start[i] = s;
    blk_size[i]  = sz;
    blk_used[i]  = u;
    blk_cnt++;
  endfunction

  function automatic void remove_blk(int i);
    if (i >= blk_cnt) return;
    for (int j = i; j < blk_cnt - 1; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_size[j]  = blk_size[j+1];
      blk_used[j]  = blk_used[j+1];
    end
    blk_cnt--;
  endfunction

  // Frees entry i and merges it with free neighbors; returns the merged index.
  function automatic int coalesce(int i);
    blk_used[i] = 1'b0;
    if (i + 1 < blk_cnt && !blk_used[i+1]) begin
      blk_size[i] += blk_size[i+1];
      remove_blk(i + 1);
    end
    if (i > 0 && !blk_used[i-1]) begin
      blk_size[i-1] += blk_size[i];
      remove_blk(i);
      i--;
    end
    return i;
  endfunction

  function automatic bit trim_blk(int i, longint unsigned keep);
    if (blk_size[i] > keep + HdrBytes && blk_cnt < MaxBlocks) begin
      insert_blk(i + 1, blk_start[i] + keep, blk_size[i] - keep, 1'b0);
      blk_size[i] = keep;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic longint unsigned hdr_round(longint unsigned bytes);
    longint unsigned need;
    need = bytes + HdrBytes;
    if (need % HdrBytes != 0) need += HdrBytes - need % HdrBytes;
    return need;
  endfunction

  function automatic int first_fit(longint unsigned bytes);
    longint unsigned need;
    need = hdr_round(bytes);
    for (int i = 0; i < blk_cnt; i++) begin
      if (!blk_used[i] && blk_size[i] >= need) begin
        void'(trim_blk(i, need));
        blk_used[i] = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [AddrW-1:0] user_addr(int i);
    return AddrW'(heap_base_q + blk_start[i] + HdrBytes);
  endfunction

  function automatic alloc_result_t serve(logic [OpW-1:0] op, longint unsigned sz,
                                          longint unsigned align, logic [AddrW-1:0] addr);
    alloc_result_t   r;
    int              k;
    int              t;
    int              hit;
    longint unsigned a;
    longint unsigned raw;
    longint unsigned prefix;
    r.status = ST_OK;
    r.addr   = '0;
    case (op)
      OP_ALLOC: begin
        k = first_fit(sz);
        if (k < 0) r.status = ST_NOFIT;
        else r.addr = user_addr(k);
      end
      OP_ALIGNED: begin
        a = 1;
        while (a < align) a <<= 1;
        k = first_fit(sz + a + HdrBytes);
        if (k < 0) begin
          r.status = ST_NOFIT;
        end else begin
          raw    = heap_base_q + blk_start[k] + HdrBytes;
          prefix = ((raw + a + HdrBytes - 1) & ~(a - 1)) - raw;
          if (blk_cnt >= MaxBlocks) begin
            // No slot for the prefix: the allocation is rolled back.
            void'(coalesce(k));
            r.status = ST_NOFIT;
          end else begin
            insert_blk(k + 1, blk_start[k] + prefix, blk_size[k] - prefix, 1'b1);
            blk_size[k] = prefix;
            t = coalesce(k) + 1;
            if (trim_blk(t, hdr_round(sz))) void'(coalesce(t + 1));
            r.addr = user_addr(t);
          end
        end
      end
      OP_FREE: begin
        if (addr != '0) begin
          hit = -1;
          for (int i = 0; i < blk_cnt; i++) begin
            if (hit < 0 && user_addr(i) == addr) hit = i;
          end
          if (hit >= 0 && blk_used[hit]) void'(coalesce(hit));
          else r.status = ST_BADFREE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    if (!rst_ni) begin
      heap_base_q  <= 0;
      blk_cnt      = 0;
      fail_count_o <= 0;
      awaited_results.delete();
    end else begin
      // Results are checked before new requests are predicted.
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d address %h", $time,
                   rsp.status, rsp.payload_address);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (exp_r.status !== rsp.status || exp_r.addr !== rsp.payload_address) begin
            $display("%0t: result mismatch: expected status %0d address %h, got %0d %h",
                     $time, exp_r.status, exp_r.addr, rsp.status, rsp.payload_address);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(serve(req.opcode, req.request_size, req.align_bytes,
                                        req.free_address));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[PaddrW-1:2] == REG_HEAP_BASE) begin
          heap_base_q <= pwdata_i;
        end else if (paddr_i[PaddrW-1:2] == REG_HEAP_SIZE) begin
          blk_start[0] = 0;
          blk_size[0]  = pwdata_i[OffW-1:0];
          blk_used[0]  = 1'b0;
          blk_cnt      = 1;
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives the heap allocator through several heap settings with directed and
// random allocate, aligned allocate and free requests under random stalls.
// ---------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int IdleLimit = 20000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                idle_cycles;
  int                hold_cycles;
  int                alloc_bias;
  logic [AddrW-1:0]  live_addrs[$];

  ffha_req_if req_ch ();
  ffha_rsp_if rsp_ch ();

  first_fit_heap_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ffha_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic reg_write(logic [PaddrW-1:0] addr, logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Withdraws the request so that nothing is taken twice, then waits for
  // every outstanding result.
  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (5) @(posedge clk_i);
  endtask

  // Writes both registers once the allocator has no request in flight.
  task automatic set_heap(logic [31:0] base, logic [23:0] bytes);
    drain();
    reg_write(PaddrW'(4 * REG_HEAP_BASE), base);
    reg_write(PaddrW'(4 * REG_HEAP_SIZE), PdataW'(bytes));
    live_addrs.delete();
  endtask

  task automatic send(logic [OpW-1:0] op, logic [OffW-1:0] bytes,
                      logic [AlignW-1:0] align, logic [AddrW-1:0] addr);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.request_size <= bytes;
    req_ch.align_bytes  <= align;
    req_ch.free_address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  function automatic logic [OffW-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return OffW'($urandom_range(0, 200));
    if (r < 85) return OffW'($urandom_range(0, 4000));
    if (r < 95) return OffW'($urandom);
    return (r < 97) ? '0 : '1;
  endfunction

  function automatic logic [AlignW-1:0] pick_align();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return AlignW'(1) << $urandom_range(0, 12);
    if (r < 80) return AlignW'(1) << $urandom_range(13, 20);
    if (r < 95) return AlignW'($urandom);
    return '0;
  endfunction

  task automatic random_item();
    int               r;
    int               idx;
    logic [AddrW-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send(OP_UNUSED, pick_size(), pick_align(), $urandom);
    end else if (r < alloc_bias) begin
      send(OP_ALLOC, pick_size(), pick_align(), $urandom);
    end else if (r < alloc_bias + 20) begin
      send(OP_ALIGNED, pick_size(), pick_align(), $urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65 && live_addrs.size() > 0) begin
        idx  = $urandom_range(0, live_addrs.size() - 1);
        addr = live_addrs[idx];
        // Keep the address now and then so that it is freed twice.
        if ($urandom_range(0, 4) != 0) live_addrs.delete(idx);
      end else if (r < 75) begin
        addr = '0;
      end else if (r < 85 && live_addrs.size() > 0) begin
        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)] + HdrBytes;
      end else begin
        addr = $urandom;
      end
      send(OP_FREE, pick_size(), pick_align(), addr);
    end
  endtask

  // Result side: random stalls, plus a long hold when one is requested.
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      if (rsp_ch.status == ST_OK && rsp_ch.payload_address != '0) begin
        live_addrs.push_back(rsp_ch.payload_address);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_ALLOC;
    req_ch.request_size = '0;
    req_ch.align_bytes  = '0;
    req_ch.free_address = '0;
    rsp_ch.ready        = 1'b0;
    idle_cycles         = 0;
    hold_cycles         = 0;
    alloc_bias          = 45;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any heap exists every allocation and every free of a non-null address must be refused.
    send(OP_ALLOC, 24'd16, 21'd1, '0);
    send(OP_ALIGNED, 24'd16, 21'd64, '0);
    send(OP_FREE, '0, 21'd1, 32'h0000_0010);
    send(OP_FREE, '0, 21'd1, '0);
    send(OP_UNUSED, '1, '1, '1);

    set_heap(32'h0, 24'd4096);
    send(OP_ALLOC, 24'd0, 21'd1, '0);
    send(OP_ALLOC, 24'hFF_FFFF, 21'd1, '0);
    send(OP_ALIGNED, 24'd10, 21'd0, '0);
    send(OP_ALIGNED, 24'd33, 21'd3, '0);
    send(OP_ALIGNED, 24'd8, 21'h10_0000, '0);
    send(OP_ALIGNED, 24'd100, 21'd256, '0);
    send(OP_ALLOC, 24'd1, 21'd1, '0);
    drain();
    send(OP_FREE, '0, 21'd1, live_addrs[0]);
    send(OP_FREE, '0, 21'd1, live_addrs[0]);
    send(OP_FREE, '0, 21'd1, live_addrs[1] + HdrBytes);
    send(OP_FREE, '0, 21'd1, '1);
    send(OP_ALLOC, 24'd3000, 21'd1, '0);
    send(OP_ALLOC, 24'd4000, 21'd1, '0);
    send(OP_UNUSED, '0, '0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_heap(32'h0, 24'd4096);
        1: set_heap(32'hFFFF_F000, 24'd8192);
        2: set_heap($urandom, 24'hFF_FFFF);
        3: set_heap(32'hFFFF_FFFF, 24'd100);
        4: set_heap($urandom, 24'd0);
        default: set_heap(32'h1234_5678, 24'd65536);
      endcase
      // The last phase mostly allocates so that the table runs full.
      alloc_bias = (ph == 5) ? 80 : 45;
      for (int n = 0; n < 190; n++) begin
        if (ph == 1 && n == 60) hold_cycles = 2000;
        if (ph == 2 && n == 90) drain();
        random_item();
      end
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/testbench.sv
